// ===== rtl/rpvc_pkg.sv =====
// rpvc_pkg: shared constants, codes and widths of the position/velocity controller
// used by every module in rtl/, no dependencies
`default_nettype none

package rpvc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W       = 32;
	localparam int MUL_W         = 33;
	localparam int PROD_W        = 2 * MUL_W;
	localparam int GAIN_W        = 31;
	localparam int DGAIN_W       = 24;
	localparam int TOL_W         = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int AXES          = 3;

	localparam logic [DGAIN_W-1:0] DGAIN_RESET = DGAIN_W'(655360);
	localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(328);

	typedef enum logic [0:0] {
		OP_TARGET = 1'b0,
		OP_ROBOT  = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET_X     = 3'd0,
		CFG_OFFSET_Y     = 3'd1,
		CFG_OFFSET_Z     = 3'd2,
		CFG_VAR_GAIN_ON  = 3'd3,
		CFG_DIST_GAIN    = 3'd4,
		CFG_ARRIVE_TOL   = 3'd5
	} cfg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/rpvc_mul.sv =====
// rpvc_mul: bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
// depends on rpvc_pkg
`default_nettype none

module rpvc_mul import rpvc_pkg::*; #(
	parameter int W = MUL_W
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [W-1:0]   a,
	input  wire logic [W-1:0]   b,
	output logic                done,
	output logic [2*W-1:0]      prod
);

	localparam int CntW = $clog2(W);

	logic            run_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [W-1:0]    a_q;
	logic [W-1:0]    hi_q;
	logic [W-1:0]    lo_q;
	logic [W:0]      sum;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CntW'(W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (run_q) begin
			hi_q <= sum[W:1];
			lo_q <= {sum[0], lo_q[W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

`default_nettype wire

// ===== rtl/rpvc_sqrt.sv =====
// rpvc_sqrt: floor integer square root, one root bit per cycle (restoring)
// depends on rpvc_pkg
`default_nettype none

module rpvc_sqrt import rpvc_pkg::*; #(
	parameter int W = MUL_W
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [2*W-1:0] rad,
	output logic                done,
	output logic [W-1:0]        root
);

	localparam int CntW = $clog2(W);

	logic            run_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [2*W-1:0]  rad_q;
	logic [W+1:0]    rem_q;
	logic [W-1:0]    root_q;
	logic [W+3:0]    rem_sh;
	logic [W+3:0]    trial;
	logic [W+3:0]    rem_dif;
	logic            ge;

	assign rem_sh  = {rem_q, rad_q[2*W-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign ge      = (rem_sh >= trial);
	assign rem_dif = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CntW'(W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[2*W-3:0], 2'b00};
			rem_q  <= ge ? rem_dif[W+1:0] : rem_sh[W+1:0];
			root_q <= {root_q[W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ===== rtl/reactive_position_velocity_control.sv =====
// robot event: velocity per axis is gain times distance to the target, once a target is received
// target event: fixed unity gain, or from the second target on with variable gain on:
//   squares of the axis distances, sum (ST_SUM_A, ST_SUM_B), root, gain multiply
// one transaction at a time; a finished result waits in the output register
// asynchronous reset clears the control, target and output state and restores register defaults
// depends on rpvc_pkg, rpvc_mul, rpvc_sqrt
`default_nettype none

module reactive_position_velocity_control import rpvc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COORD_W-1:0]   cfg_data,
	input  wire logic                 cmd_valid,
	output logic                      cmd_stall,
	input  wire logic                 opcode,
	input  wire logic signed [31:0]   pos_x,
	input  wire logic signed [31:0]   pos_y,
	input  wire logic signed [31:0]   pos_z,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output logic signed [31:0]        vel_x,
	output logic signed [31:0]        vel_y,
	output logic signed [31:0]        vel_z,
	output logic                      forward_state
);

	localparam logic [GAIN_W-1:0] GainOne = GAIN_W'(1) << FRAC_BITS;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TGT_CHK,
		ST_SQ_RUN,
		ST_SUM_A,
		ST_SUM_B,
		ST_SQRT_GO,
		ST_SQRT_RUN,
		ST_GMUL_GO,
		ST_GMUL_RUN,
		ST_GAIN_SET,
		ST_VEL_CHK,
		ST_VEL_RUN,
		ST_OUT
	} state_t;

	state_t state_q;

	logic signed [COORD_W-1:0] off_q    [AXES];
	logic                      var_gain_q;
	logic [DGAIN_W-1:0]        dgain_q;
	logic [TOL_W-1:0]          tol_q;

	logic signed [COORD_W-1:0] tgt_q    [AXES];
	logic signed [COORD_W-1:0] start_q  [AXES];
	logic signed [COORD_W-1:0] robot_q  [AXES];
	logic [GAIN_W-1:0]         gain_q;
	logic [1:0]                seen_q;
	logic                      tgt_rcv_q;
	logic                      reached_q;
	logic [PROD_W-1:0]         sum_q;

	logic                      res_valid_q;
	logic signed [COORD_W-1:0] vel_q    [AXES];
	logic                      fwd_q;

	logic signed [COORD_W-1:0] pos_in   [AXES];
	logic [COORD_W:0]          tadd     [AXES];
	logic signed [COORD_W-1:0] tsat     [AXES];
	logic [COORD_W:0]          diff     [AXES];
	logic [MUL_W-1:0]          mag      [AXES];
	logic [COORD_W:0]          sdiff    [AXES];
	logic [COORD_W:0]          smag     [AXES];
	logic [PROD_W-1:0]         vsh      [AXES];
	logic [COORD_W-1:0]        vmag     [AXES];
	logic signed [COORD_W-1:0] vel_next [AXES];
	logic [MUL_W-1:0]          mul_a    [AXES];
	logic [MUL_W-1:0]          mul_b    [AXES];
	logic [PROD_W-1:0]         prod     [AXES];
	logic [AXES-1:0]           lane_done;
	logic                      in_tol;
	logic                      need_sq;
	logic                      mul_start;
	logic                      mul_done;
	logic                      sqrt_done;
	logic [MUL_W-1:0]          root;
	logic [PROD_W-1:0]         gsh;
	logic [GAIN_W-1:0]         gain_next;

	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;

	assign need_sq   = var_gain_q && (seen_q == 2'd2);
	assign mul_start = (state_q == ST_TGT_CHK && need_sq)
	                || (state_q == ST_VEL_CHK && tgt_rcv_q)
	                || (state_q == ST_GMUL_GO);
	assign mul_done  = &lane_done;

	always_comb begin
		in_tol = 1'b1;
		for (int i = 0; i < AXES; i++) begin
			tadd[i] = {pos_in[i][COORD_W-1], pos_in[i]} + {off_q[i][COORD_W-1], off_q[i]};
			if (tadd[i][COORD_W] != tadd[i][COORD_W-1])
				tsat[i] = tadd[i][COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
				                           : {1'b0, {(COORD_W-1){1'b1}}};
			else
				tsat[i] = tadd[i][COORD_W-1:0];

			diff[i] = {tgt_q[i][COORD_W-1], tgt_q[i]} - {robot_q[i][COORD_W-1], robot_q[i]};
			mag[i]  = diff[i][COORD_W] ? (~diff[i] + 1'b1) : diff[i];

			sdiff[i] = {robot_q[i][COORD_W-1], robot_q[i]} - {start_q[i][COORD_W-1], start_q[i]};
			smag[i]  = sdiff[i][COORD_W] ? (~sdiff[i] + 1'b1) : sdiff[i];
			if (smag[i] >= {{(COORD_W+1-TOL_W){1'b0}}, tol_q})
				in_tol = 1'b0;

			vsh[i] = prod[i] >> FRAC_BITS;
			if ((|vsh[i][PROD_W-1:COORD_W]) || (vsh[i][COORD_W-1] && (|vsh[i][COORD_W-2:0])))
				vmag[i] = {1'b1, {(COORD_W-1){1'b0}}};
			else
				vmag[i] = vsh[i][COORD_W-1:0];
			if (diff[i][COORD_W])
				vel_next[i] = ~vmag[i] + 1'b1;
			else if (vmag[i][COORD_W-1])
				vel_next[i] = {1'b0, {(COORD_W-1){1'b1}}};
			else
				vel_next[i] = vmag[i];

			if (state_q == ST_GMUL_GO && i == 0) begin
				mul_a[i] = root;
				mul_b[i] = MUL_W'(dgain_q);
			end else if (state_q == ST_TGT_CHK) begin
				mul_a[i] = mag[i];
				mul_b[i] = mag[i];
			end else begin
				mul_a[i] = mag[i];
				mul_b[i] = MUL_W'(gain_q);
			end
		end
	end

	assign gsh       = prod[0] >> FRAC_BITS;
	assign gain_next = (|gsh[PROD_W-1:GAIN_W]) ? '1 : gsh[GAIN_W-1:0];

	for (genvar g = 0; g < AXES; g++) begin : g_lane
		rpvc_mul #(
			.W (MUL_W)
		) u_mul (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (mul_start),
			.a      (mul_a[g]),
			.b      (mul_b[g]),
			.done   (lane_done[g]),
			.prod   (prod[g])
		);
	end

	rpvc_sqrt #(
		.W (MUL_W)
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_SQRT_GO),
		.rad    (sum_q),
		.done   (sqrt_done),
		.root   (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			var_gain_q  <= 1'b0;
			dgain_q     <= DGAIN_RESET;
			tol_q       <= TOL_RESET;
			gain_q      <= '0;
			seen_q      <= '0;
			tgt_rcv_q   <= 1'b0;
			reached_q   <= 1'b0;
			sum_q       <= '0;
			res_valid_q <= 1'b0;
			fwd_q       <= 1'b0;
			for (int i = 0; i < AXES; i++) begin
				off_q[i]   <= '0;
				tgt_q[i]   <= '0;
				start_q[i] <= '0;
				robot_q[i] <= '0;
				vel_q[i]   <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_OFFSET_X:    off_q[0]   <= cfg_data;
					CFG_OFFSET_Y:    off_q[1]   <= cfg_data;
					CFG_OFFSET_Z:    off_q[2]   <= cfg_data;
					CFG_VAR_GAIN_ON: var_gain_q <= cfg_data[0];
					CFG_DIST_GAIN:   dgain_q    <= cfg_data[DGAIN_W-1:0];
					CFG_ARRIVE_TOL:  tol_q      <= cfg_data[TOL_W-1:0];
					default: ;
				endcase
			end

			if (res_valid_q && !res_stall && (state_q != ST_OUT))
				res_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (opcode == OP_TARGET) begin
							for (int i = 0; i < AXES; i++) begin
								tgt_q[i] <= tsat[i];
								if (seen_q == 2'd0)
									start_q[i] <= tsat[i];
							end
							if (seen_q != 2'd2)
								seen_q <= seen_q + 2'd1;
							tgt_rcv_q <= 1'b1;
							state_q   <= ST_TGT_CHK;
						end else begin
							for (int i = 0; i < AXES; i++)
								robot_q[i] <= pos_in[i];
							state_q <= ST_VEL_CHK;
						end
					end
				end
				ST_TGT_CHK: begin
					if (need_sq) begin
						state_q <= ST_SQ_RUN;
					end else begin
						gain_q  <= GainOne;
						state_q <= ST_IDLE;
					end
				end
				ST_SQ_RUN: begin
					if (mul_done)
						state_q <= ST_SUM_A;
				end
				ST_SUM_A: begin
					sum_q   <= prod[0] + prod[1];
					state_q <= ST_SUM_B;
				end
				ST_SUM_B: begin
					sum_q   <= sum_q + prod[2];
					state_q <= ST_SQRT_GO;
				end
				ST_SQRT_GO: begin
					state_q <= ST_SQRT_RUN;
				end
				ST_SQRT_RUN: begin
					if (sqrt_done)
						state_q <= ST_GMUL_GO;
				end
				ST_GMUL_GO: begin
					state_q <= ST_GMUL_RUN;
				end
				ST_GMUL_RUN: begin
					if (mul_done)
						state_q <= ST_GAIN_SET;
				end
				ST_GAIN_SET: begin
					gain_q  <= gain_next;
					state_q <= ST_IDLE;
				end
				ST_VEL_CHK: begin
					state_q <= tgt_rcv_q ? ST_VEL_RUN : ST_IDLE;
				end
				ST_VEL_RUN: begin
					if (mul_done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!res_valid_q || !res_stall) begin
						for (int i = 0; i < AXES; i++)
							vel_q[i] <= vel_next[i];
						fwd_q       <= reached_q || in_tol;
						reached_q   <= reached_q || in_tol;
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd_stall     = (state_q != ST_IDLE);
	assign res_valid     = res_valid_q;
	assign vel_x         = vel_q[0];
	assign vel_y         = vel_q[1];
	assign vel_z         = vel_q[2];
	assign forward_state = fwd_q;

endmodule

`default_nettype wire

// ===== rtl/rpvc_checker.sv =====
// rpvc_checker: port-level assertions for the position/velocity controller
// depends on rpvc_pkg; bound to reactive_position_velocity_control below
`default_nettype none

module rpvc_checker import rpvc_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               cmd_valid,
	input wire logic               cmd_stall,
	input wire logic               opcode,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire logic signed [31:0] vel_x,
	input wire logic signed [31:0] vel_y,
	input wire logic signed [31:0] vel_z,
	input wire logic               forward_state
);

	logic accept;

	assign accept = cmd_valid && !cmd_stall;

	// one transaction at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> cmd_stall)
		else $error("block took a transaction while busy");

	// no result rises right after an accepted target event
	a_target_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (opcode == OP_TARGET) |=> !$rose(res_valid))
		else $error("result right after a target transaction");

	// a result only comes out of work in progress
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_stall))
		else $error("result appeared while idle");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(vel_x) && $stable(vel_y)
			&& $stable(vel_z) && $stable(forward_state))
		else $error("stalled result changed");

endmodule

bind reactive_position_velocity_control rpvc_checker u_rpvc_checker (.*);

`default_nettype wire
